/* sv/lpd_pkg.sv */
// types and constants for the length prefixed deframer
package lpd_pkg;

	// phase of the deframer, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_LENGTH = 3'b010,
		PH_DATA   = 3'b100
	} phase_t;

	// frame status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SHORT      = 2'd1,
		ST_OVERRUN    = 2'd2,
		ST_COUNT_MISS = 2'd3
	} status_t;

	localparam int unsigned HEADER_BYTES = 6;
	localparam int unsigned LENGTH_BYTES = 4;
	localparam int unsigned COUNT_BYTES  = 2;

	localparam logic [2:0]  HDR_LEN_DONE = 3'(HEADER_BYTES - COUNT_BYTES);
	localparam logic [2:0]  HDR_DONE     = 3'(HEADER_BYTES);
	localparam logic [2:0]  LEN_DONE     = 3'(LENGTH_BYTES);
	localparam logic [31:0] COUNT_LEN    = 32'(COUNT_BYTES);

endpackage

/* sv/length_prefixed_deframer_unit.sv */
// length prefixed message deframer: one stream byte in, one result item out
//
// Takes one byte of the message stream per input item and gives exactly one result
// item for it. A message is a six-byte big-endian header (32-bit total length that
// counts the two count bytes, then a 16-bit part count) followed by parts, each a
// 32-bit big-endian length and that many payload bytes. Payload bytes come out with
// data_valid set and their part index; the byte that completes a part (empty parts
// too) sets part_end; the byte that completes or aborts a message sets tlast and
// carries the frame status (0 ok, 1 total below two, 2 part overruns total, 3 part
// count mismatch). After tlast the next byte is read as a new header.
// Rate: one item per clock cycle sustained while the result side takes items. Each
// byte waits in the input register, the counter updates and compares run between it
// and the result register, and the result register loads the result item, which is
// then offered. The result register and the input register stall together under
// back-pressure.
module length_prefixed_deframer_unit
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] part_number
	output logic [3:0]  m_axis_tuser,   // [0] data_valid, [1] part_end, [3:2] frame_status
	output logic        m_axis_tlast    // message_end
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result register
	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic [15:0] part_number_q;
	logic        data_valid_q;
	logic        part_end_q;
	logic        message_end_q;
	status_t     status_q;

	// deframer state
	phase_t      phase_q;
	logic [2:0]  fcnt_q;
	logic [31:0] fshift_q;
	logic [31:0] body_q;
	logic [15:0] expected_q;
	logic [15:0] seen_q;
	logic [31:0] prem_q;

	// next state and result
	phase_t      phase_d;
	logic [2:0]  fcnt_d;
	logic [31:0] fshift_d;
	logic [31:0] body_d;
	logic [15:0] expected_d;
	logic [15:0] seen_d;
	logic [31:0] prem_d;

	logic [7:0]  r_data;
	logic        r_valid;
	logic [15:0] r_part;
	logic        r_pend;
	logic        r_mend;
	status_t     r_status;

	logic        fin;
	logic        fin_with_part;
	status_t     fin_status;

	logic [31:0] shift_in;
	logic [2:0]  cnt_inc;
	logic [31:0] body_dec;
	logic [31:0] prem_dec;
	logic [15:0] seen_inc;

	logic        out_free;
	logic        step;

	// the result register frees when empty or being taken
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign shift_in = {fshift_q[23:0], byte_s1};
	assign cnt_inc  = fcnt_q + 3'd1;
	assign body_dec = (body_q != '0) ? body_q - 32'd1 : body_q;
	assign prem_dec = (prem_q != '0) ? prem_q - 32'd1 : prem_q;
	assign seen_inc = seen_q + 16'd1;

	always_comb begin
		phase_d       = phase_q;
		fcnt_d        = fcnt_q;
		fshift_d      = fshift_q;
		body_d        = body_q;
		expected_d    = expected_q;
		seen_d        = seen_q;
		prem_d        = prem_q;
		r_data        = '0;
		r_valid       = 1'b0;
		r_part        = '0;
		r_pend        = 1'b0;
		r_mend        = 1'b0;
		r_status      = ST_OK;
		fin           = 1'b0;
		fin_with_part = 1'b0;
		fin_status    = ST_OK;

		case (phase_q)
			PH_DATA: begin
				// payload byte of the current part
				r_data  = byte_s1;
				r_valid = 1'b1;
				r_part  = seen_q;
				prem_d  = prem_dec;
				body_d  = body_dec;
				if (prem_dec == '0) begin
					r_pend = 1'b1;
					seen_d = seen_inc;
					if (body_dec == '0) begin
						fin           = 1'b1;
						fin_with_part = 1'b1;
						fin_status    = (seen_inc != expected_q) ? ST_COUNT_MISS : ST_OK;
					end else begin
						phase_d  = PH_LENGTH;
						fcnt_d   = '0;
						fshift_d = '0;
					end
				end
			end
			PH_LENGTH: begin
				fshift_d = shift_in;
				fcnt_d   = cnt_inc;
				body_d   = body_dec;
				if (cnt_inc < LEN_DONE) begin
					// body ran out inside a length field
					if (body_dec == '0) begin
						fin        = 1'b1;
						fin_status = ST_OVERRUN;
					end
				end else begin
					fcnt_d   = '0;
					fshift_d = '0;
					if (shift_in > body_dec) begin
						fin        = 1'b1;
						fin_status = ST_OVERRUN;
					end else if (seen_q == expected_q) begin
						// more parts than announced
						fin        = 1'b1;
						fin_status = ST_COUNT_MISS;
					end else if (shift_in == '0) begin
						// empty part ends on its last length byte
						r_pend = 1'b1;
						r_part = seen_q;
						seen_d = seen_inc;
						if (body_dec == '0) begin
							fin           = 1'b1;
							fin_with_part = 1'b1;
							fin_status    = (seen_inc != expected_q) ? ST_COUNT_MISS : ST_OK;
						end
					end else begin
						prem_d  = shift_in;
						phase_d = PH_DATA;
					end
				end
			end
			default: begin
				// header phase, unused codes fall back here
				phase_d  = PH_HEADER;
				fshift_d = shift_in;
				fcnt_d   = cnt_inc;
				if (cnt_inc == HDR_LEN_DONE) begin
					body_d   = shift_in;
					fshift_d = '0;
				end else if (cnt_inc >= HDR_DONE) begin
					expected_d = shift_in[15:0];
					fshift_d   = '0;
					fcnt_d     = '0;
					seen_d     = '0;
					if (body_q < COUNT_LEN) begin
						fin        = 1'b1;
						fin_status = ST_SHORT;
					end else begin
						body_d = body_q - COUNT_LEN;
						if (body_q == COUNT_LEN) begin
							// empty body: check count against zero parts
							fin        = 1'b1;
							fin_status = (shift_in[15:0] != '0) ? ST_COUNT_MISS : ST_OK;
						end else begin
							phase_d = PH_LENGTH;
						end
					end
				end
			end
		endcase

		// message end: report and return to header wait
		if (fin) begin
			r_mend   = 1'b1;
			r_status = fin_status;
			if (!fin_with_part) begin
				r_part = seen_d;
			end
			phase_d    = PH_HEADER;
			fcnt_d     = '0;
			fshift_d   = '0;
			body_d     = '0;
			expected_d = '0;
			seen_d     = '0;
			prem_d     = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			fcnt_q     <= '0;
			fshift_q   <= '0;
			body_q     <= '0;
			expected_q <= '0;
			seen_q     <= '0;
			prem_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			fcnt_q     <= fcnt_d;
			fshift_q   <= fshift_d;
			body_q     <= body_d;
			expected_q <= expected_d;
			seen_q     <= seen_d;
			prem_q     <= prem_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			data_byte_q   <= r_data;
			part_number_q <= r_part;
			data_valid_q  <= r_valid;
			part_end_q    <= r_pend;
			message_end_q <= r_mend;
			status_q      <= r_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {part_number_q, data_byte_q};
	assign m_axis_tuser  = {status_q, part_end_q, data_valid_q};
	assign m_axis_tlast  = message_end_q;

endmodule

/* bench/tb_length_prefixed_deframer_unit.sv */
// self-checking testbench for the length prefixed deframer: streamed messages against a predictor
`timescale 1ns / 100ps

module tb_length_prefixed_deframer_unit
	import lpd_pkg::*;
();

	// one result item as the block should emit it
	typedef struct {
		logic [7:0]  data_byte;
		logic        data_valid;
		logic [15:0] part_number;
		logic        part_end;
		logic        message_end;
		status_t     status;
	} deframe_result_t;

	// shapes of generated messages
	typedef enum int unsigned {
		MSG_WELL_FORMED,
		MSG_COUNT_OFF,
		MSG_EXTRA_PART,
		MSG_OVERRUN,
		MSG_CUT_LENGTH,
		MSG_SHORT_TOTAL,
		MSG_NOISE
	} msg_kind_t;

	// predictor of the deframer plus the store of results still to arrive
	class deframe_scoreboard;
		phase_t          phase;
		logic [2:0]      byte_cnt;
		logic [31:0]     shift_reg;
		logic [31:0]     body_left;
		logic [15:0]     parts_expected;
		logic [15:0]     parts_found;
		logic [31:0]     part_left;
		deframe_result_t res;
		deframe_result_t expected_q[$];
		int unsigned     fail_count;

		function new();
			reset_state();
			fail_count = 0;
		endfunction

		function void reset_state();
			phase          = PH_HEADER;
			byte_cnt       = '0;
			shift_reg      = '0;
			body_left      = '0;
			parts_expected = '0;
			parts_found    = '0;
			part_left      = '0;
		endfunction

		function status_t count_status();
			return (parts_found != parts_expected) ? ST_COUNT_MISS : ST_OK;
		endfunction

		// close or abort the message; the part index is kept when a part ends here too
		function void end_message(status_t st, bit with_part);
			res.message_end = 1'b1;
			res.status      = st;
			if (!with_part)
				res.part_number = parts_found;
			reset_state();
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// work out the result that one accepted stream byte causes
		function void note_input(logic [7:0] b);
			logic [31:0] len;
			res.data_byte   = '0;
			res.data_valid  = 1'b0;
			res.part_number = '0;
			res.part_end    = 1'b0;
			res.message_end = 1'b0;
			res.status      = ST_OK;
			case (phase)
				PH_DATA: begin
					res.data_byte   = b;
					res.data_valid  = 1'b1;
					res.part_number = parts_found;
					if (part_left != 0)
						part_left--;
					if (body_left != 0)
						body_left--;
					if (part_left == 0) begin
						res.part_end = 1'b1;
						parts_found++;
						if (body_left == 0)
							end_message(count_status(), 1'b1);
						else begin
							phase     = PH_LENGTH;
							byte_cnt  = '0;
							shift_reg = '0;
						end
					end
				end
				PH_LENGTH: begin
					shift_reg = {shift_reg[23:0], b};
					byte_cnt++;
					if (body_left != 0)
						body_left--;
					if (byte_cnt < LEN_DONE) begin
						// body used up inside a length field
						if (body_left == 0)
							end_message(ST_OVERRUN, 1'b0);
					end else begin
						len       = shift_reg;
						byte_cnt  = '0;
						shift_reg = '0;
						if (len > body_left)
							end_message(ST_OVERRUN, 1'b0);
						else if (parts_found == parts_expected)
							end_message(ST_COUNT_MISS, 1'b0);
						else if (len == 0) begin
							// empty part ends on its last length byte
							res.part_end    = 1'b1;
							res.part_number = parts_found;
							parts_found++;
							if (body_left == 0)
								end_message(count_status(), 1'b1);
						end else begin
							part_left = len;
							phase     = PH_DATA;
						end
					end
				end
				default: begin
					phase     = PH_HEADER;
					shift_reg = {shift_reg[23:0], b};
					byte_cnt++;
					if (byte_cnt == HDR_LEN_DONE) begin
						body_left = shift_reg;
						shift_reg = '0;
					end else if (byte_cnt >= HDR_DONE) begin
						parts_expected = shift_reg[15:0];
						shift_reg      = '0;
						byte_cnt       = '0;
						parts_found    = '0;
						if (body_left < COUNT_LEN)
							end_message(ST_SHORT, 1'b0);
						else begin
							body_left -= COUNT_LEN;
							if (body_left == 0)
								end_message(count_status(), 1'b0);
							else
								phase = PH_LENGTH;
						end
					end
				end
			endcase
			expected_q = {expected_q, res};
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
				fail_count++;
			end
		endfunction

		// compare one result item with the oldest expectation
		function void check_result(logic [23:0] tdata, logic [3:0] tuser, logic tlast);
			deframe_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result item with nothing expected, tdata %h tuser %h tlast %b",
					$time, tdata, tuser, tlast);
				fail_count++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("data_byte",    want.data_byte,   tdata[7:0]);
			compare_field("part_number",  want.part_number, tdata[23:8]);
			compare_field("data_valid",   want.data_valid,  tuser[0]);
			compare_field("part_end",     want.part_end,    tuser[1]);
			compare_field("frame_status", want.status,      tuser[3:2]);
			compare_field("message_end",  want.message_end, tlast);
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	deframe_scoreboard sb = new();
	logic [7:0]        tx_bytes[$];
	int unsigned       tx_idle_pct = 0;
	int unsigned       rx_idle_pct = 0;
	logic              hold_req    = 1'b0;

	always #6 clk = ~clk;

	length_prefixed_deframer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// queue the top nbytes of w, most significant first
	task automatic push_be(logic [31:0] w, int unsigned nbytes);
		for (int unsigned k = 0; k < nbytes; k++)
			tx_bytes = {tx_bytes, w[31 - 8 * k -: 8]};
	endtask

	task automatic push_header(logic [31:0] total, logic [15:0] count);
		push_be(total, 4);
		push_be({count, 16'h0000}, 2);
	endtask

	task automatic push_payload(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			tx_bytes = {tx_bytes, 8'($urandom_range(255))};
	endtask

	// one message, mostly well formed; broken ones stop where the block aborts so the
	// next header lines up again
	task automatic queue_message();
		msg_kind_t   kind;
		int unsigned roll, nparts, stop_at, tail_bytes, i;
		int unsigned lens[4];
		logic [31:0] total, prefix;
		logic [15:0] count;
		bit          len_only;
		roll = $urandom_range(99);
		kind = roll < 60 ? MSG_WELL_FORMED : roll < 70 ? MSG_COUNT_OFF :
			roll < 78 ? MSG_EXTRA_PART : roll < 86 ? MSG_OVERRUN :
			roll < 92 ? MSG_CUT_LENGTH : roll < 96 ? MSG_SHORT_TOTAL : MSG_NOISE;
		case (kind)
			MSG_EXTRA_PART, MSG_OVERRUN, MSG_CUT_LENGTH: nparts = $urandom_range(1, 4);
			MSG_SHORT_TOTAL, MSG_NOISE:                   nparts = 0;
			default:                                      nparts = $urandom_range(0, 4);
		endcase
		for (i = 0; i < 4; i++)
			lens[i] = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
		stop_at    = nparts;
		len_only   = 1'b0;
		tail_bytes = 0;
		count      = 16'(nparts);
		case (kind)
			// more parts promised than sent, no wrap so it stays above the real number
			MSG_COUNT_OFF: count = 16'(nparts + $urandom_range(1, 65531));
			MSG_EXTRA_PART: begin
				count    = 16'(nparts - 1);
				stop_at  = nparts - 1;
				len_only = 1'b1;
			end
			MSG_OVERRUN: begin
				stop_at = $urandom_range(nparts - 1);
				if (lens[stop_at] == 0)
					lens[stop_at] = $urandom_range(1, 6);
				len_only = 1'b1;
			end
			MSG_CUT_LENGTH: begin
				stop_at    = $urandom_range(nparts - 1);
				tail_bytes = $urandom_range(1, 3);
			end
			default: ;
		endcase
		prefix = 0;
		for (i = 0; i < stop_at; i++)
			prefix += 4 + lens[i];
		case (kind)
			MSG_EXTRA_PART:  total = 2 + prefix + 4 + lens[stop_at];
			MSG_OVERRUN:     total = 2 + prefix + 4 + $urandom_range(lens[stop_at] - 1);
			MSG_CUT_LENGTH:  total = 2 + prefix + tail_bytes;
			MSG_SHORT_TOTAL: begin
				total = $urandom_range(1);
				count = 16'($urandom);
			end
			MSG_NOISE: begin
				// random body of up to one length field, always consumed whole
				tail_bytes = $urandom_range(4);
				total      = 2 + tail_bytes;
				count      = 16'($urandom);
			end
			default:         total = 2 + prefix;
		endcase
		push_header(total, count);
		if (kind == MSG_NOISE)
			push_payload(tail_bytes);
		else begin
			for (i = 0; i < stop_at; i++) begin
				push_be(lens[i], 4);
				push_payload(lens[i]);
			end
			if (len_only)
				push_be(lens[stop_at], 4);
			if (tail_bytes != 0)
				push_be(lens[stop_at], tail_bytes);
		end
	endtask

	task automatic queue_random(int unsigned budget);
		int unsigned target;
		target = tx_bytes.size() + budget;
		while (tx_bytes.size() < target)
			queue_message();
	endtask

	// offer queued bytes with random gaps; an item is taken when tready is seen at the edge
	task automatic send_stream();
		logic [7:0] b;
		while (tx_bytes.size() != 0) begin
			if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				b = tx_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= b;
				do @(posedge clk); while (!s_axis_tready);
				sb.note_input(b);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// result side: random back-pressure, one long hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (hold_req && hold_left == 0)
				hold_left = 400;
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_req <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalling
		tx_idle_pct = 21;
		rx_idle_pct = 84;
		// total below two with an all-ones count
		push_header(32'd1, 16'hffff);
		// empty body but one part promised
		push_header(32'd2, 16'd1);
		// an empty part then a one-byte part, all-ones payload
		push_header(32'd11, 16'd2);
		push_be(32'd0, 4);
		push_be(32'd1, 4);
		tx_bytes = {tx_bytes, 8'hff};
		queue_random(280);
		send_stream();
		wait_drained();

		// the other way round
		tx_idle_pct = 84;
		rx_idle_pct = 21;
		queue_random(280);
		send_stream();
		wait_drained();

		// no idling, with a long receiver hold-off so the input stalls
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req <= 1'b1;
		queue_random(290);
		send_stream();
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
sv/lpd_pkg.sv
sv/length_prefixed_deframer_unit.sv
bench/tb_length_prefixed_deframer_unit.sv
